FILE: hw/rtl/sradx_pkg.sv
// Shared types and constants for the sum-to-radix-digits block.
package sradx_pkg;

	localparam int OPERAND_BITS = 30;
	localparam int MAX_DIGITS   = 31;
	localparam int SUM_BITS     = OPERAND_BITS + 1;
	localparam int DEPTH_BITS   = $clog2(MAX_DIGITS + 1);
	localparam int IDX_BITS     = $clog2(MAX_DIGITS);
	localparam int STEP_BITS    = $clog2(SUM_BITS);
	localparam int DIGIT_BITS   = 4;
	localparam int RADIX_BITS   = 4;
	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);

	localparam logic [RADIX_BITS-1:0] RADIX_RESET = RADIX_BITS'(10);
	localparam logic [RADIX_BITS-1:0] RADIX_MIN   = RADIX_BITS'(2);
	localparam logic [RADIX_BITS-1:0] RADIX_MAX   = RADIX_BITS'(10);

	typedef struct packed {
		logic [OPERAND_BITS-1:0] addend_a;
		logic [OPERAND_BITS-1:0] addend_b;
	} req_t;

	typedef struct packed {
		logic [DIGIT_BITS-1:0] digit;
		logic                  last_digit;
	} rsp_t;

	typedef struct packed {
		logic [SUM_BITS-1:0]   sum;
		logic [RADIX_BITS-1:0] base;
	} job_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_EMIT
	} back_state_t;

endpackage

FILE: hw/rtl/sradx_front.sv
// Front end: radix register, request intake, sum and base clamp.
module sradx_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [sradx_pkg::RADIX_BITS-1:0] cfg_data,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  sradx_pkg::req_t                req,
	output logic                           job_valid,
	input  logic                           job_ready,
	output sradx_pkg::job_t                job
);
	import sradx_pkg::*;

	logic [RADIX_BITS-1:0] radix_q;
	logic [RADIX_BITS-1:0] base_eff;
	logic                  valid_s1;
	job_t                  job_s1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (cfg_valid) begin
			radix_q <= cfg_data;
		end
	end

	// Clamp out-of-range bases to the nearest legal one.
	always_comb begin
		if (radix_q < RADIX_MIN) begin
			base_eff = RADIX_MIN;
		end else if (radix_q > RADIX_MAX) begin
			base_eff = RADIX_MAX;
		end else begin
			base_eff = radix_q;
		end
	end

	assign req_ready = !valid_s1 || job_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			job_s1.sum  <= {1'b0, req.addend_a} + {1'b0, req.addend_b};
			job_s1.base <= base_eff;
		end
	end

	assign job_valid = valid_s1;
	assign job       = job_s1;

endmodule

FILE: hw/rtl/sradx_queue.sv
// Short job queue between front and back end.
module sradx_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  sradx_pkg::job_t push_data,
	output logic            pop_valid,
	input  logic            pop_ready,
	output sradx_pkg::job_t pop_data
);
	import sradx_pkg::*;

	job_t                 entry_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QCNT_BITS-1:0] count_q;
	logic                 do_push;
	logic                 do_pop;

	assign push_ready = (count_q != QCNT_BITS'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

FILE: hw/rtl/sradx_back.sv
// Back end: bit-serial divider, digit stack and output register.
module sradx_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            job_valid,
	output logic            job_ready,
	input  sradx_pkg::job_t job,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output sradx_pkg::rsp_t rsp
);
	import sradx_pkg::*;

	back_state_t           state_q;
	back_state_t           state_d;
	logic [SUM_BITS-1:0]   quot_q;
	logic [DIGIT_BITS-1:0] rem_q;
	logic [RADIX_BITS-1:0] base_q;
	logic [STEP_BITS-1:0]  step_q;
	logic [DEPTH_BITS-1:0] depth_q;
	logic [DIGIT_BITS-1:0] stack_q [MAX_DIGITS];
	logic                  rsp_valid_q;
	rsp_t                  rsp_q;

	logic [DIGIT_BITS:0]   trial;
	logic                  ge;
	logic [DIGIT_BITS-1:0] rem_next;
	logic [SUM_BITS-1:0]   quot_next;
	logic                  load_job;
	logic                  div_step;
	logic                  digit_done;
	logic                  emit_load;
	logic                  emit_last;
	logic [DEPTH_BITS-1:0] depth_dec;

	// One restoring-division step: shift in the next dividend bit.
	assign trial     = {rem_q, quot_q[SUM_BITS-1]};
	assign ge        = (trial >= {1'b0, base_q});
	assign rem_next  = ge ? DIGIT_BITS'(trial - {1'b0, base_q}) : DIGIT_BITS'(trial);
	assign quot_next = {quot_q[SUM_BITS-2:0], ge};
	assign depth_dec = depth_q - 1'b1;
	assign emit_last = (depth_q == DEPTH_BITS'(1));

	always_comb begin
		state_d    = state_q;
		job_ready  = 1'b0;
		load_job   = 1'b0;
		div_step   = 1'b0;
		digit_done = 1'b0;
		emit_load  = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				job_ready = 1'b1;
				if (job_valid) begin
					load_job = 1'b1;
					state_d  = BK_DIV;
				end
			end
			BK_DIV: begin
				div_step = 1'b1;
				if (step_q == '0) begin
					digit_done = 1'b1;
					if (quot_next == '0 || depth_q == DEPTH_BITS'(MAX_DIGITS - 1)) begin
						state_d = BK_EMIT;
					end
				end
			end
			BK_EMIT: begin
				if (!rsp_valid_q || rsp_ready) begin
					emit_load = 1'b1;
					if (emit_last) begin
						state_d = BK_IDLE;
					end
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			depth_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_job) begin
				depth_q <= '0;
			end else if (digit_done) begin
				depth_q <= depth_q + 1'b1;
			end else if (emit_load) begin
				depth_q <= depth_dec;
			end
			if (emit_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Divider datapath: restart each digit on the quotient of the last one.
	always_ff @(posedge clk) begin
		if (load_job) begin
			quot_q <= job.sum;
			base_q <= job.base;
			rem_q  <= '0;
			step_q <= STEP_BITS'(SUM_BITS - 1);
		end else if (div_step) begin
			quot_q <= quot_next;
			if (digit_done) begin
				rem_q  <= '0;
				step_q <= STEP_BITS'(SUM_BITS - 1);
			end else begin
				rem_q  <= rem_next;
				step_q <= step_q - 1'b1;
			end
		end
	end

	// Digit stack: push remainders, pop most significant first.
	always_ff @(posedge clk) begin
		if (digit_done) begin
			stack_q[depth_q[IDX_BITS-1:0]] <= rem_next;
		end
		if (emit_load) begin
			rsp_q.digit      <= stack_q[depth_dec[IDX_BITS-1:0]];
			rsp_q.last_digit <= emit_last;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: hw/rtl/sum_to_radix_digits_unit.sv
// Top level of the sum-to-radix-digits block.
// Each request carries two unsigned addends. Their sum (one bit wider than an
// addend) is converted to the base held in the radix register (2 to 10; codes
// 0 and 1 act as base 2, codes 11 to 15 as base 10; reset value 10) and sent
// out as one response per digit, most significant digit first, with
// last_digit set on the least significant digit. A zero sum gives the single
// digit 0. The front end takes a request, forms the sum and the clamped base
// and pushes the job into a two-entry queue, so new requests keep coming in
// while the back end works. The back end divides with a restoring
// shift-subtract unit that retires one dividend bit per cycle, so each digit
// costs 31 divide steps, the last of which also pushes the remainder on the
// digit stack. When all digits are stacked, the back end pops them, most
// significant first, into the output register and then returns to idle to
// take the next job. The radix is sampled when a request is taken, so write
// it only while the block is idle.
// The configuration channel is always ready.
module sum_to_radix_digits_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [sradx_pkg::RADIX_BITS-1:0] cfg_data,
	input  logic                             req_valid,
	output logic                             req_ready,
	input  sradx_pkg::req_t                  req,
	output logic                             rsp_valid,
	input  logic                             rsp_ready,
	output sradx_pkg::rsp_t                  rsp
);
	import sradx_pkg::*;

	// Front to queue.
	logic fq_valid;
	logic fq_ready;
	job_t fq_job;
	// Queue to back.
	logic qb_valid;
	logic qb_ready;
	job_t qb_job;

	// Hold the radix, add the operands, clamp the base.
	sradx_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.job_valid (fq_valid),
		.job_ready (fq_ready),
		.job       (fq_job)
	);

	// Decouple intake from the slow divider.
	sradx_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_data  (fq_job),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_data   (qb_job)
	);

	// Divide, stack the digits, drive responses.
	sradx_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (qb_valid),
		.job_ready (qb_ready),
		.job       (qb_job),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

FILE: hw/rtl/sradx_checker.sv
// Port-level checks for the sum-to-radix-digits block, bound to the top level.
module sradx_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            cfg_valid,
	input logic            cfg_ready,
	input logic            rsp_valid,
	input logic            rsp_ready,
	input sradx_pkg::rsp_t rsp
);
	import sradx_pkg::*;

	// Set while the next response opens a new digit string.
	logic first_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
		end else if (rsp_valid && rsp_ready) begin
			first_q <= rsp.last_digit;
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.digit <= DIGIT_BITS'(9))
		else $error("digit out of range");

	a_string_continues: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready && !rsp.last_digit |=> rsp_valid)
		else $error("digit string broken before last digit");

	a_no_leading_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && first_q && !rsp.last_digit |-> rsp.digit != '0)
		else $error("leading zero digit");

	a_cfg_always_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind sum_to_radix_digits_unit sradx_checker u_sradx_checker (.*);

FILE: sim/tb_top.sv
// Self-checking testbench for the sum-to-radix-digits unit.
module tb_top;
	import sradx_pkg::*;

	localparam int WATCHDOG_LIMIT  = 20000;
	localparam int SETTLE_CYCLES   = 16;
	localparam int HOLD_OFF_CYCLES = 1500;
	localparam int MAX_REPORTS     = 50;
	localparam int CHUNK_ITEMS     = 15;
	localparam int CHUNKS          = 3;
	localparam int PRESSURE_ITEMS  = 20;

	localparam logic [OPERAND_BITS-1:0] ADDEND_MAX = '1;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [RADIX_BITS-1:0] cfg_data  = '0;
	logic                  req_valid = 1'b0;
	logic                  req_ready;
	req_t                  req       = '0;
	logic                  rsp_valid;
	logic                  rsp_ready = 1'b0;
	rsp_t                  rsp;

	// Testbench copy of the radix register and the digits still owed by the block.
	logic [RADIX_BITS-1:0] radix_code = RADIX_RESET;
	rsp_t                  pending_digits[$];
	rsp_t                  want_digit;

	int err_count          = 0;
	int quiet_cycles       = 0;
	int hold_cycles        = 0;
	int sender_idle_pct    = 0;
	int receiver_stall_pct = 0;

	sum_to_radix_digits_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	always #10 clk = ~clk;

	// Clamp a register code to the base the block really divides by.
	function automatic logic [RADIX_BITS-1:0] active_base(input logic [RADIX_BITS-1:0] code);
		if (code < RADIX_MIN)
			return RADIX_MIN;
		if (code > RADIX_MAX)
			return RADIX_MAX;
		return code;
	endfunction

	// Convert a + b to the current base and queue the digits, most significant first.
	function automatic void predict_digits(input logic [OPERAND_BITS-1:0] a,
			input logic [OPERAND_BITS-1:0] b);
		logic [SUM_BITS-1:0]   total;
		logic [SUM_BITS-1:0]   base;
		logic [DIGIT_BITS-1:0] remainders[MAX_DIGITS];
		int                    depth;
		rsp_t                  item;
		base  = SUM_BITS'(active_base(radix_code));
		total = SUM_BITS'(a) + SUM_BITS'(b);
		depth = 0;
		// Push remainders least significant first; cap at the digit stack size.
		do begin
			remainders[depth] = DIGIT_BITS'(total % base);
			depth++;
			total = total / base;
		end while (total != 0 && depth < MAX_DIGITS);
		for (int k = 0; k < depth; k++) begin
			item.digit      = remainders[depth - 1 - k];
			item.last_digit = (k == depth - 1);
			pending_digits.push_back(item);
		end
	endfunction

	// Mix of full-range, tiny, random-width and near-maximum operands.
	function automatic logic [OPERAND_BITS-1:0] rand_addend();
		logic [OPERAND_BITS-1:0] value;
		int                      width;
		value = OPERAND_BITS'($urandom);
		case ($urandom_range(0, 3))
			0: ;
			1: value = OPERAND_BITS'($urandom_range(0, 20));
			2: begin
				width = $urandom_range(1, OPERAND_BITS);
				value = value & (ADDEND_MAX >> (OPERAND_BITS - width));
			end
			default: value = ADDEND_MAX - OPERAND_BITS'($urandom_range(0, 20));
		endcase
		return value;
	endfunction

	task automatic flag_error(input string what);
		if (err_count < MAX_REPORTS)
			$display("ERROR at %0t: %s", $time, what);
		err_count++;
	endtask

	// Offer one request; hold valid and payload until the block takes it.
	task automatic offer_sum(input logic [OPERAND_BITS-1:0] a, input logic [OPERAND_BITS-1:0] b);
		bit taken;
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= '{addend_a: a, addend_b: b};
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = req_ready;
			@(posedge clk);
		end
		predict_digits(a, b);
	endtask

	// Drop valid, wait for every owed digit, then let the back end go quiet.
	task automatic settle();
		req_valid <= 1'b0;
		while (pending_digits.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write the radix register; call only with the block idle.
	task automatic write_radix(input logic [RADIX_BITS-1:0] code);
		bit taken;
		cfg_valid <= 1'b1;
		cfg_data  <= code;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end
		cfg_valid  <= 1'b0;
		radix_code = code;
	endtask

	// Reset base: zero sum, operand extremes, single digit to two-digit carry.
	task automatic test_reset_base();
		offer_sum('0, '0);
		offer_sum(ADDEND_MAX, ADDEND_MAX);
		offer_sum(ADDEND_MAX, '0);
		offer_sum('0, ADDEND_MAX);
		offer_sum(OPERAND_BITS'(9), '0);
		offer_sum(OPERAND_BITS'(5), OPERAND_BITS'(5));
		offer_sum(OPERAND_BITS'(1), '0);
		settle();
	endtask

	// Every register code, including those clamped to base 2 and base 10.
	task automatic test_every_radix_code();
		logic [RADIX_BITS-1:0] base;
		for (int code = 0; code < (1 << RADIX_BITS); code++) begin
			write_radix(RADIX_BITS'(code));
			base = active_base(RADIX_BITS'(code));
			// Longest output on the binary settings and on code 15, a carry into a new digit elsewhere.
			if (base == RADIX_MIN || code == (1 << RADIX_BITS) - 1)
				offer_sum(ADDEND_MAX, ADDEND_MAX);
			else
				offer_sum(OPERAND_BITS'(base - 1), OPERAND_BITS'(1));
			settle();
		end
	endtask

	// Random sums in chunks, with a fresh radix between chunks.
	task automatic test_random_traffic(input int idle_pct, input int stall_pct);
		sender_idle_pct    = idle_pct;
		receiver_stall_pct = stall_pct;
		for (int c = 0; c < CHUNKS; c++) begin
			write_radix(RADIX_BITS'($urandom_range(0, (1 << RADIX_BITS) - 1)));
			for (int i = 0; i < CHUNK_ITEMS; i++)
				offer_sum(rand_addend(), rand_addend());
			settle();
		end
	endtask

	// Long receiver hold-off while requests keep coming, so the job queue fills.
	task automatic test_backpressure();
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		write_radix(RADIX_BITS'($urandom_range(RADIX_MIN, RADIX_MAX)));
		hold_cycles = HOLD_OFF_CYCLES;
		for (int i = 0; i < PRESSURE_ITEMS; i++)
			offer_sum(OPERAND_BITS'($urandom), OPERAND_BITS'($urandom));
		settle();
	endtask

	// Response side: honor a pending hold-off, else stall at the phase's rate.
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles--;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
		end
	end

	// Compare each digit that will be taken at the next rising edge.
	always @(negedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_digits.size() == 0) begin
				flag_error($sformatf("digit %0d with no request outstanding", rsp.digit));
			end else begin
				want_digit = pending_digits.pop_front();
				if (rsp.digit !== want_digit.digit)
					flag_error($sformatf("digit %0d, expected %0d", rsp.digit,
						want_digit.digit));
				if (rsp.last_digit !== want_digit.last_digit)
					flag_error($sformatf("last_digit %0b, expected %0b", rsp.last_digit,
						want_digit.last_digit));
			end
		end
	end

	// Abort if no channel moves anything for too long.
	always @(negedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired at %0t", $time);
			$display("sum_to_radix_digits_unit regression: fail");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_base();
		test_every_radix_code();
		test_random_traffic(0, 0);
		test_random_traffic(66, 0);
		test_random_traffic(0, 66);
		test_random_traffic(8, 8);
		test_backpressure();
		if (err_count == 0)
			$display("sum_to_radix_digits_unit regression: pass");
		else
			$display("sum_to_radix_digits_unit regression: fail");
		$finish;
	end

endmodule

FILE: sum_to_radix_digits_unit.f
hw/rtl/sradx_pkg.sv
hw/rtl/sradx_front.sv
hw/rtl/sradx_queue.sv
hw/rtl/sradx_back.sv
hw/rtl/sum_to_radix_digits_unit.sv
hw/rtl/sradx_checker.sv
sim/tb_top.sv
